### rtl/core/sqlx_pkg.sv
// shared types, codes and keyword table of the sql query lexer
package sqlx_pkg;

  // token kinds
  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_KEYWORD = 4'd1;
  localparam logic [3:0] KIND_LOGICAL = 4'd2;
  localparam logic [3:0] KIND_NUMBER  = 4'd3;
  localparam logic [3:0] KIND_STRING  = 4'd4;
  localparam logic [3:0] KIND_LPAREN  = 4'd5;
  localparam logic [3:0] KIND_RPAREN  = 4'd6;
  localparam logic [3:0] KIND_COMPARE = 4'd7;
  localparam logic [3:0] KIND_MATH    = 4'd8;
  localparam logic [3:0] KIND_END     = 4'd9;

  // comparison codes
  localparam logic [2:0] CMP_GT = 3'd0;
  localparam logic [2:0] CMP_GE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_EQ = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  // math codes
  localparam logic [2:0] MATH_ADD = 3'd0;
  localparam logic [2:0] MATH_SUB = 3'd1;
  localparam logic [2:0] MATH_MUL = 3'd2;
  localparam logic [2:0] MATH_DIV = 3'd3;
  localparam logic [2:0] MATH_MOD = 3'd4;

  // query bytes with a meaning of their own
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // reserved words, upper case, packed right aligned
  localparam int unsigned KW_NUM = 12;
  localparam logic [47:0] KW_WORD [KW_NUM] = '{
    48'h0000_0041_4E44,  // AND
    48'h0000_0000_4F52,  // OR
    48'h5345_4C45_4354,  // SELECT
    48'h0057_4845_5245,  // WHERE
    48'h494E_5345_5254,  // INSERT
    48'h0000_4A4F_494E,  // JOIN
    48'h0000_4652_4F4D,  // FROM
    48'h0000_494E_544F,  // INTO
    48'h5550_4441_5445,  // UPDATE
    48'h0000_0053_4554,  // SET
    48'h5641_4C55_4553,  // VALUES
    48'h0000_0000_4F4E   // ON
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd2, 3'd6, 3'd5, 3'd6, 3'd4, 3'd4, 3'd4, 3'd6, 3'd3, 3'd6, 3'd2
  };
  localparam logic [3:0] KW_KIND [KW_NUM] = '{
    KIND_LOGICAL, KIND_LOGICAL, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD,
    KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD
  };
  localparam logic [3:0] KW_CODE [KW_NUM] = '{
    4'd10, 4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
  };

  // result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  word;
    logic [2:0]  cmp;
    logic [2:0]  math;
    logic [11:0] start;
    logic [6:0]  len;
    logic [8:0]  index;
    logic        ovf;
    logic        last;
  } tok_t;

  // up to two tokens finished by one item, first one in r0
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t r0;
    tok_t r1;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

endpackage

### rtl/core/sql_query_lexer_unit.sv
// sql query lexer: one query byte per item in, one token per item out
// A query byte (tuser low) or the end-of-query item (tuser high) is taken every cycle: it is
// registered, one lexer step turns it into at most two tokens, and these go into a four-entry
// result queue that drives the output. A byte that closes one token and is itself a symbol
// (such as the paren in "a(") yields two tokens, which leave the queue one after the other; the
// input stalls only while the queue holds more than two tokens. Each result passes the input
// register and the queue before it appears. Tokens beyond MAX_TOKENS-1 per query are dropped
// and the END token, which always comes and carries tlast, reports this in its overflow bit.
module sql_query_lexer_unit #(
  parameter int unsigned MAX_TOKENS = 512,
  parameter int unsigned MAX_TEXT   = 127,
  parameter int unsigned MAX_QUERY  = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // word_code, compare_code, math_code, text_start, text_length,
  // token_index, overflow, zero fill
  output logic [39:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast
);
  import sqlx_pkg::*;

  logic       in_vld_q;
  logic       act_q;
  logic [7:0] chr_q;
  logic       space;
  logic       step;
  logic       pop;
  push_t      push;
  tok_t       head;

  assign s_axis_tready = !in_vld_q || space;
  assign step          = in_vld_q && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_q <= s_axis_tuser;
      chr_q <= s_axis_tdata;
    end
  end

  sqlx_step #(
    .MAX_TOKENS (MAX_TOKENS),
    .MAX_TEXT   (MAX_TEXT),
    .MAX_QUERY  (MAX_QUERY)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .act_i  (act_q),
    .chr_i  (chr_q),
    .push_o (push)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  sqlx_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .space_o (space)
  );

  assign m_axis_tdata = {1'b0, head.ovf, head.index, head.len, head.start,
                         head.math, head.cmp, head.word};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // second result only together with a first one
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.v1 |-> push.v0)
    else $error("second token pushed without a first");

  // results only come out of a processed item
  a_push_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.v0 |-> step)
    else $error("token pushed with no item in work");

  // tlast only ever comes on the END token
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (head.kind == KIND_END))
    else $error("tlast on a token that is not END");

  // an item waiting without queue room is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !space) |=> in_vld_q)
    else $error("held item lost while queue full");

endmodule

### rtl/core/sqlx_kw_match.sv
// parallel reserved word compare on the upper-cased word prefix
module sqlx_kw_match #(
  parameter int unsigned RW = 7
) (
  input  logic [47:0]   pfx_i,
  input  logic [RW-1:0] run_i,
  output logic [3:0]    kind_o,
  output logic [3:0]    code_o
);
  import sqlx_pkg::*;

  always_comb begin
    kind_o = KIND_IDENT;
    code_o = 4'd0;
    // lowest table entry wins
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (run_i == RW'(KW_LEN[k]) && pfx_i == KW_WORD[k]) begin
        kind_o = KW_KIND[k];
        code_o = KW_CODE[k];
      end
    end
  end

endmodule

### rtl/core/sqlx_step.sv
// lexer state and the per-byte step that finishes tokens
module sqlx_step #(
  parameter int unsigned MAX_TOKENS = 512,
  parameter int unsigned MAX_TEXT   = 127,
  parameter int unsigned MAX_QUERY  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                act_i,
  input  logic [7:0]          chr_i,
  output sqlx_pkg::push_t     push_o
);
  import sqlx_pkg::*;

  localparam int unsigned TW = $clog2(MAX_TOKENS);
  localparam int unsigned RW = $clog2(MAX_TEXT + 1);
  localparam int unsigned PW = $clog2(MAX_QUERY);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_DOT    = 3'd4;
  localparam logic [2:0] MODE_CMP    = 3'd5;

  localparam logic [1:0] PEND_GT  = 2'd0;
  localparam logic [1:0] PEND_LT  = 2'd1;
  localparam logic [1:0] PEND_EQ  = 2'd2;
  localparam logic [1:0] PEND_NOT = 2'd3;

  localparam logic [TW-1:0] TOK_CAP = TW'(MAX_TOKENS - 1);

  logic [2:0]    mode_q, mode_d;
  logic          dot_q, dot_d;
  logic [1:0]    pend_q, pend_d;
  logic [PW-1:0] begin_q, begin_d;
  logic [RW-1:0] run_q, run_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [TW-1:0] tok_q, tok_d;
  logic [47:0]   pfx_q, pfx_d;
  logic          drop_q, drop_d;

  logic [3:0]    kw_kind;
  logic [3:0]    kw_code;
  logic [RW-1:0] run_inc;
  logic [PW-1:0] pos_inc;
  logic          word_chr;
  logic          consumed;
  logic          c0_v, c1_v, c1_end;
  tok_t          c0, c1;
  logic          ok0, ok1;
  logic [TW-1:0] tok_mid;
  logic [2:0]    cmp_plain, cmp_witheq;
  tok_t          r1;

  sqlx_kw_match #(
    .RW (RW)
  ) u_kw (
    .pfx_i  (pfx_q),
    .run_i  (run_q),
    .kind_o (kw_kind),
    .code_o (kw_code)
  );

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [3:0] word,
                                  input logic [2:0] cmp, input logic [2:0] math,
                                  input logic [PW-1:0] start, input logic [RW-1:0] len);
    tok_t t;
    t       = '0;
    t.kind  = kind;
    t.word  = word;
    t.cmp   = cmp;
    t.math  = math;
    t.start = 12'(start);
    t.len   = 7'(len);
    return t;
  endfunction

  always_comb begin
    run_inc  = (run_q < RW'(MAX_TEXT)) ? run_q + 1'b1 : run_q;
    pos_inc  = (pos_q < PW'(MAX_QUERY - 1)) ? pos_q + 1'b1 : pos_q;
    word_chr = is_alpha(chr_i) || is_digit(chr_i) || chr_i == CH_UNDER;
    case (pend_q)
      PEND_GT: begin
        cmp_plain  = CMP_GT;
        cmp_witheq = CMP_GE;
      end
      PEND_LT: begin
        cmp_plain  = CMP_LT;
        cmp_witheq = CMP_LE;
      end
      PEND_EQ: begin
        cmp_plain  = CMP_EQ;
        cmp_witheq = CMP_EQ;
      end
      default: begin
        cmp_plain  = CMP_GT;
        cmp_witheq = CMP_NE;
      end
    endcase

    mode_d   = mode_q;
    dot_d    = dot_q;
    pend_d   = pend_q;
    begin_d  = begin_q;
    run_d    = run_q;
    pos_d    = pos_inc;
    pfx_d    = pfx_q;
    consumed = 1'b0;
    c0_v     = 1'b0;
    c1_v     = 1'b0;
    c1_end   = 1'b0;
    c0       = '0;
    c1       = '0;

    // token still open when the byte or the end item arrives
    case (mode_q)
      MODE_IDENT:  c0 = mk_tok(kw_kind, kw_code, 3'd0, 3'd0, begin_q, run_q);
      MODE_NUMBER: c0 = mk_tok(KIND_NUMBER, 4'd0, 3'd0, 3'd0, begin_q, run_q);
      MODE_STRING: c0 = mk_tok(KIND_STRING, 4'd0, 3'd0, 3'd0, begin_q, run_q);
      MODE_CMP: begin
        if (!act_i && chr_i == CH_EQ) begin
          c0 = mk_tok(KIND_COMPARE, 4'd0, cmp_witheq, 3'd0, begin_q, '0);
        end else begin
          c0 = mk_tok(KIND_COMPARE, 4'd0, cmp_plain, 3'd0, begin_q, '0);
        end
      end
      default: c0 = '0;
    endcase

    if (act_i) begin
      c0_v = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER) || (mode_q == MODE_STRING) ||
             (mode_q == MODE_CMP && pend_q != PEND_NOT);
      c1_v   = 1'b1;
      c1_end = 1'b1;
      c1     = mk_tok(KIND_END, 4'd0, 3'd0, 3'd0, pos_q, '0);
      c1.last = 1'b1;
      mode_d  = MODE_IDLE;
      dot_d   = 1'b0;
      pend_d  = PEND_GT;
      begin_d = '0;
      run_d   = '0;
      pos_d   = '0;
      pfx_d   = '0;
    end else begin
      case (mode_q)
        MODE_IDENT: begin
          if (word_chr) begin
            if (run_q < RW'(6)) pfx_d = {pfx_q[39:0], to_upper(chr_i)};
            run_d    = run_inc;
            consumed = 1'b1;
          end else begin
            c0_v = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(chr_i)) begin
            run_d    = run_inc;
            consumed = 1'b1;
          end else if (chr_i == CH_DOT && !dot_q) begin
            dot_d    = 1'b1;
            run_d    = run_inc;
            consumed = 1'b1;
          end else begin
            c0_v = 1'b1;
          end
        end
        MODE_STRING: begin
          consumed = 1'b1;
          if (chr_i == CH_QUOTE) begin
            c0_v   = 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            run_d = run_inc;
          end
        end
        MODE_DOT: begin
          // a dot followed by a digit opens a number
          if (is_digit(chr_i)) begin
            mode_d   = MODE_NUMBER;
            dot_d    = 1'b1;
            run_d    = RW'(2);
            consumed = 1'b1;
          end
        end
        MODE_CMP: begin
          if (chr_i == CH_EQ) begin
            c0_v     = 1'b1;
            mode_d   = MODE_IDLE;
            consumed = 1'b1;
          end else begin
            c0_v = pend_q != PEND_NOT;
          end
        end
        default: ;
      endcase

      // byte not taken by the open token starts a new one
      if (!consumed) begin
        mode_d  = MODE_IDLE;
        begin_d = pos_q;
        if (is_alpha(chr_i) || chr_i == CH_UNDER) begin
          mode_d = MODE_IDENT;
          run_d  = RW'(1);
          pfx_d  = {40'd0, to_upper(chr_i)};
        end else if (is_digit(chr_i)) begin
          mode_d = MODE_NUMBER;
          run_d  = RW'(1);
          dot_d  = 1'b0;
        end else begin
          case (chr_i)
            CH_DOT: mode_d = MODE_DOT;
            CH_QUOTE: begin
              mode_d  = MODE_STRING;
              run_d   = '0;
              begin_d = pos_inc;
            end
            CH_LPAR: begin
              c1_v = 1'b1;
              c1   = mk_tok(KIND_LPAREN, 4'd0, 3'd0, 3'd0, pos_q, '0);
            end
            CH_RPAR: begin
              c1_v = 1'b1;
              c1   = mk_tok(KIND_RPAREN, 4'd0, 3'd0, 3'd0, pos_q, '0);
            end
            CH_GT: begin
              mode_d = MODE_CMP;
              pend_d = PEND_GT;
            end
            CH_LT: begin
              mode_d = MODE_CMP;
              pend_d = PEND_LT;
            end
            CH_EQ: begin
              mode_d = MODE_CMP;
              pend_d = PEND_EQ;
            end
            CH_BANG: begin
              mode_d = MODE_CMP;
              pend_d = PEND_NOT;
            end
            CH_PLUS: begin
              c1_v = 1'b1;
              c1   = mk_tok(KIND_MATH, 4'd0, 3'd0, MATH_ADD, pos_q, '0);
            end
            CH_MINUS: begin
              c1_v = 1'b1;
              c1   = mk_tok(KIND_MATH, 4'd0, 3'd0, MATH_SUB, pos_q, '0);
            end
            CH_STAR: begin
              c1_v = 1'b1;
              c1   = mk_tok(KIND_MATH, 4'd0, 3'd0, MATH_MUL, pos_q, '0);
            end
            CH_SLASH: begin
              c1_v = 1'b1;
              c1   = mk_tok(KIND_MATH, 4'd0, 3'd0, MATH_DIV, pos_q, '0);
            end
            CH_PCT: begin
              c1_v = 1'b1;
              c1   = mk_tok(KIND_MATH, 4'd0, 3'd0, MATH_MOD, pos_q, '0);
            end
            default: ;
          endcase
        end
      end
    end

    // token cap, end token is never dropped
    ok0      = c0_v && (tok_q < TOK_CAP);
    tok_mid  = tok_q + TW'(ok0);
    ok1      = c1_v && (c1_end || tok_mid < TOK_CAP);
    drop_d   = drop_q || (c0_v && !ok0) || (c1_v && !ok1);
    tok_d    = tok_mid + TW'(ok1 && !c1_end);
    c0.index = 9'(tok_q);
    r1       = c1;
    r1.index = 9'(tok_mid);
    r1.ovf   = c1_end && drop_d;
    if (act_i) begin
      tok_d  = '0;
      drop_d = 1'b0;
    end

    push_o.v0 = step_i && (ok0 || ok1);
    push_o.v1 = step_i && ok0 && ok1;
    push_o.r0 = ok0 ? c0 : r1;
    push_o.r1 = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      dot_q   <= 1'b0;
      pend_q  <= PEND_GT;
      begin_q <= '0;
      run_q   <= '0;
      pos_q   <= '0;
      tok_q   <= '0;
      pfx_q   <= '0;
      drop_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      dot_q   <= dot_d;
      pend_q  <= pend_d;
      begin_q <= begin_d;
      run_q   <= run_d;
      pos_q   <= pos_d;
      tok_q   <= tok_d;
      pfx_q   <= pfx_d;
      drop_q  <= drop_d;
    end
  end

endmodule

### rtl/core/sqlx_res_fifo.sv
// four-entry result queue, two writes and one read per cycle
module sqlx_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sqlx_pkg::push_t push_i,
  input  logic            pop_i,
  output sqlx_pkg::tok_t  head_o,
  output logic            valid_o,
  output logic            space_o
);
  import sqlx_pkg::*;

  tok_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d;
  logic [QAW-1:0] rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic [QAW-1:0] wr_nxt;

  always_comb begin
    wr_nxt  = wr_q + 1'b1;
    wr_d    = wr_q + QAW'(push_i.v0) + QAW'(push_i.v1);
    rd_d    = rd_q + QAW'(pop_i);
    cnt_d   = cnt_q + (QAW + 1)'(push_i.v0) + (QAW + 1)'(push_i.v1) - (QAW + 1)'(pop_i);
    head_o  = mem_q[rd_q];
    valid_o = cnt_q != '0;
    // room for the worst case of two results
    space_o = cnt_q <= (QAW + 1)'(QDEPTH - 2);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_q] <= push_i.r0;
    if (push_i.v1) mem_q[wr_nxt] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### verif/sql_query_lexer_unit_test.sv
`timescale 1ns / 100ps
// testbench of the sql query lexer: streamed queries, token stream checked by a scoreboard
module sql_query_lexer_unit_test;
  import sqlx_pkg::*;

  localparam int unsigned TOKEN_CAP    = 512;
  localparam int unsigned TEXT_CAP     = 127;
  localparam int unsigned POS_CAP      = 4096;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [3:0] NO_WORD  = 4'd0;
  localparam logic [3:0] WORD_AND = 4'd10;
  localparam logic [3:0] WORD_OR  = 4'd11;
  localparam logic [2:0] NO_CODE  = 3'd0;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] SYM_BYTES [12] = '{
    CH_LPAR, CH_RPAR, CH_GT, CH_LT, CH_EQ, CH_BANG,
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_DOT
  };
  localparam logic [7:0] CMP_BYTES [4] = '{CH_GT, CH_LT, CH_EQ, CH_BANG};
  localparam logic [7:0] BLANK_BYTES [3] = '{8'h09, 8'h0A, 8'h00};

  typedef enum logic [2:0] {
    LX_IDLE, LX_WORD, LX_NUMBER, LX_STRING, LX_DOT, LX_CMP
  } lex_mode_e;

  typedef enum logic [1:0] {PEND_GT, PEND_LT, PEND_EQ, PEND_BANG} pend_cmp_e;

  class token_scoreboard;
    tok_t        expected_q[$];
    int          failures;
    string       kw_text[12];
    lex_mode_e   mode;
    bit          dot_seen;
    pend_cmp_e   pend;
    int          begin_pos;
    int          run_len;
    int          pos;
    int          emitted;
    logic [47:0] prefix;
    bit          dropped_any;

    function new();
      kw_text = '{"AND", "OR", "SELECT", "WHERE", "INSERT", "JOIN", "FROM", "INTO",
                  "UPDATE", "SET", "VALUES", "ON"};
      failures = 0;
      clear_query();
    endfunction

    function void clear_query();
      mode        = LX_IDLE;
      dot_seen    = 1'b0;
      pend        = PEND_GT;
      begin_pos   = 0;
      run_len     = 0;
      pos         = 0;
      emitted     = 0;
      prefix      = '0;
      dropped_any = 1'b0;
    endfunction

    function bit letter_byte(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit_byte(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic [47:0] pack_text(string s);
      logic [47:0] v;
      v = '0;
      for (int i = 0; i < s.len(); i++) v = {v[39:0], s[i]};
      return v;
    endfunction

    // the last token slot of a query stays free for END
    function void push_token(logic [3:0] kind, logic [3:0] word, logic [2:0] cmpc,
                             logic [2:0] mathc, int start, int len);
      tok_t t;
      if (emitted >= TOKEN_CAP - 1) begin
        dropped_any = 1'b1;
        return;
      end
      t       = '0;
      t.kind  = kind;
      t.word  = word;
      t.cmp   = cmpc;
      t.math  = mathc;
      t.start = 12'(start);
      t.len   = 7'(len);
      t.index = 9'(emitted);
      expected_q.push_back(t);
      emitted++;
    endfunction

    function void grow();
      if (run_len < TEXT_CAP) run_len++;
    endfunction

    function void add_letter(logic [7:0] c);
      logic [7:0] u;
      u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      if (run_len < 6) prefix = {prefix[39:0], u};
      grow();
    endfunction

    function void close_word();
      for (int k = 0; k < 12; k++) begin
        if (run_len == kw_text[k].len() && prefix == pack_text(kw_text[k])) begin
          if (k < 2)
            push_token(KIND_LOGICAL, (k == 0) ? WORD_AND : WORD_OR, NO_CODE, NO_CODE,
                       begin_pos, run_len);
          else
            push_token(KIND_KEYWORD, 4'(k - 2), NO_CODE, NO_CODE, begin_pos, run_len);
          return;
        end
      end
      push_token(KIND_IDENT, NO_WORD, NO_CODE, NO_CODE, begin_pos, run_len);
    endfunction

    // a lone bang yields nothing
    function void close_cmp(bit with_eq);
      case (pend)
        PEND_GT: push_token(KIND_COMPARE, NO_WORD, with_eq ? CMP_GE : CMP_GT, NO_CODE,
                            begin_pos, 0);
        PEND_LT: push_token(KIND_COMPARE, NO_WORD, with_eq ? CMP_LE : CMP_LT, NO_CODE,
                            begin_pos, 0);
        PEND_EQ: push_token(KIND_COMPARE, NO_WORD, CMP_EQ, NO_CODE, begin_pos, 0);
        default: if (with_eq) push_token(KIND_COMPARE, NO_WORD, CMP_NE, NO_CODE, begin_pos, 0);
      endcase
    endfunction

    function void start_token(logic [7:0] c, int p);
      mode      = LX_IDLE;
      begin_pos = p;
      if (letter_byte(c) || c == CH_UNDER) begin
        mode    = LX_WORD;
        run_len = 0;
        prefix  = '0;
        add_letter(c);
      end else if (digit_byte(c)) begin
        mode     = LX_NUMBER;
        run_len  = 1;
        dot_seen = 1'b0;
      end else if (c == CH_DOT) begin
        mode = LX_DOT;
      end else if (c == CH_QUOTE) begin
        mode    = LX_STRING;
        run_len = 0;
        if (p < POS_CAP - 1) begin_pos = p + 1;
      end else begin
        case (c)
          CH_LPAR:  push_token(KIND_LPAREN, NO_WORD, NO_CODE, NO_CODE, p, 0);
          CH_RPAR:  push_token(KIND_RPAREN, NO_WORD, NO_CODE, NO_CODE, p, 0);
          CH_GT:    begin mode = LX_CMP; pend = PEND_GT; end
          CH_LT:    begin mode = LX_CMP; pend = PEND_LT; end
          CH_EQ:    begin mode = LX_CMP; pend = PEND_EQ; end
          CH_BANG:  begin mode = LX_CMP; pend = PEND_BANG; end
          CH_PLUS:  push_token(KIND_MATH, NO_WORD, NO_CODE, MATH_ADD, p, 0);
          CH_MINUS: push_token(KIND_MATH, NO_WORD, NO_CODE, MATH_SUB, p, 0);
          CH_STAR:  push_token(KIND_MATH, NO_WORD, NO_CODE, MATH_MUL, p, 0);
          CH_SLASH: push_token(KIND_MATH, NO_WORD, NO_CODE, MATH_DIV, p, 0);
          CH_PCT:   push_token(KIND_MATH, NO_WORD, NO_CODE, MATH_MOD, p, 0);
          default: ;
        endcase
      end
    endfunction

    function void note_item(logic act, logic [7:0] c);
      tok_t t;
      int   p;
      bit   used;
      p    = pos;
      used = 1'b0;
      if (act) begin
        case (mode)
          LX_WORD:   close_word();
          LX_NUMBER: push_token(KIND_NUMBER, NO_WORD, NO_CODE, NO_CODE, begin_pos, run_len);
          LX_STRING: push_token(KIND_STRING, NO_WORD, NO_CODE, NO_CODE, begin_pos, run_len);
          LX_CMP:    close_cmp(1'b0);
          default: ;
        endcase
        t       = '0;
        t.kind  = KIND_END;
        t.start = 12'(p);
        t.index = 9'(emitted);
        t.ovf   = dropped_any;
        t.last  = 1'b1;
        expected_q.push_back(t);
        clear_query();
        return;
      end
      case (mode)
        LX_WORD: begin
          if (letter_byte(c) || digit_byte(c) || c == CH_UNDER) begin
            add_letter(c);
            used = 1'b1;
          end else close_word();
        end
        LX_NUMBER: begin
          if (digit_byte(c)) begin
            grow();
            used = 1'b1;
          end else if (c == CH_DOT && !dot_seen) begin
            dot_seen = 1'b1;
            grow();
            used = 1'b1;
          end else push_token(KIND_NUMBER, NO_WORD, NO_CODE, NO_CODE, begin_pos, run_len);
        end
        LX_STRING: begin
          if (c == CH_QUOTE) begin
            push_token(KIND_STRING, NO_WORD, NO_CODE, NO_CODE, begin_pos, run_len);
            mode = LX_IDLE;
          end else grow();
          used = 1'b1;
        end
        LX_DOT: begin
          if (digit_byte(c)) begin
            mode     = LX_NUMBER;
            dot_seen = 1'b1;
            run_len  = 2;
            used     = 1'b1;
          end
        end
        LX_CMP: begin
          if (c == CH_EQ) begin
            close_cmp(1'b1);
            mode = LX_IDLE;
            used = 1'b1;
          end else close_cmp(1'b0);
        end
        default: ;
      endcase
      if (!used) start_token(c, p);
      if (pos < POS_CAP - 1) pos++;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: token %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_token(logic [39:0] data, logic [3:0] kind, logic last);
      tok_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: token with nothing pending: expected none, actual data %h kind %0d last %b",
                 $time, data, kind, last);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      check_field("kind", e.kind, kind);
      check_field("word_code", e.word, data[3:0]);
      check_field("compare_code", e.cmp, data[6:4]);
      check_field("math_code", e.math, data[9:7]);
      check_field("text_start", e.start, data[21:10]);
      check_field("text_length", e.len, data[28:22]);
      check_field("token_index", e.index, data[37:29]);
      check_field("overflow", e.ovf, data[38]);
      check_field("last", e.last, last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // char_code
  logic        s_axis_tuser  = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // word_code, compare_code, math_code, text_start, text_length,
  // token_index, overflow, zero fill
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;         // token_kind
  logic        m_axis_tlast;

  token_scoreboard board;
  logic [7:0]      qbuf[$];
  bit              src_gaps    = 1'b0;
  bit              sink_stalls = 1'b0;
  int unsigned     cycle_count = 0;

  sql_query_lexer_unit #(
    .MAX_TOKENS(TOKEN_CAP),
    .MAX_TEXT  (TEXT_CAP),
    .MAX_QUERY (POS_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !sink_stalls || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // starts and ends on a falling edge
  task automatic send_item(input logic act, input logic [7:0] ch);
    while (src_gaps && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_item(act, ch);
    @(negedge clk_i);
  endtask

  task automatic wait_for_tokens();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (board.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_query(input bit pause_mid);
    for (int i = 0; i < qbuf.size(); i++) begin
      if (pause_mid && i == qbuf.size() / 2) wait_for_tokens();
      send_item(1'b0, qbuf[i]);
    end
    send_item(1'b1, 8'($urandom_range(255)));
    qbuf.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) qbuf.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  task automatic push_word(input int len);
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) qbuf.push_back(8'("A" + r));
    else if (r < 52) qbuf.push_back(8'("a" + r - 26));
    else qbuf.push_back(CH_UNDER);
    repeat (len - 1) qbuf.push_back(word_char());
  endtask

  task automatic push_digits(input int n);
    repeat (n) qbuf.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic push_string(input int len, input bit closed);
    logic [7:0] b;
    qbuf.push_back(CH_QUOTE);
    repeat (len) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
      qbuf.push_back(b);
    end
    if (closed) qbuf.push_back(CH_QUOTE);
  endtask

  // mostly well-formed token sequences, some raw byte noise
  task automatic gen_query(output bit noise);
    int         n_tok;
    int         form;
    string      w;
    logic [7:0] b;
    noise = 1'b0;
    if ($urandom_range(99) < 15) begin
      noise = 1'b1;
      repeat ($urandom_range(1, 16)) qbuf.push_back(8'($urandom_range(255)));
      return;
    end
    n_tok = $urandom_range(1, 10);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          w = board.kw_text[$urandom_range(0, 11)];
          for (int i = 0; i < w.len(); i++) begin
            b = w[i];
            if ($urandom_range(1)) b = b + 8'd32;
            qbuf.push_back(b);
          end
        end
        2: push_word($urandom_range(1, 12));
        3: begin
          form = $urandom_range(0, 3);
          if (form != 2) push_digits($urandom_range(1, 5));
          if (form != 0) begin
            qbuf.push_back(CH_DOT);
            push_digits($urandom_range(1, 4));
          end
          if (form == 3) begin
            qbuf.push_back(CH_DOT);
            push_digits($urandom_range(1, 3));
          end
        end
        4: push_string($urandom_range(0, 8), (t < n_tok - 1) || ($urandom_range(3) != 0));
        5, 6: qbuf.push_back(SYM_BYTES[$urandom_range(0, 11)]);
        7: qbuf.push_back(8'($urandom_range(255)));
        8: begin
          qbuf.push_back(CMP_BYTES[$urandom_range(0, 3)]);
          qbuf.push_back(CH_EQ);
        end
        default: push_word(($urandom_range(0, 19) == 0) ? $urandom_range(120, 140)
                                                         : $urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 4))
        0, 1: ;
        2, 3: qbuf.push_back(CH_SPACE);
        default: qbuf.push_back(BLANK_BYTES[$urandom_range(0, 2)]);
      endcase
    end
  endtask

  initial begin
    bit noise;
    int round;
    int random_items;
    board = new();
    round = 0;
    random_items = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // OR, paren, number with a second dot, dot-digit number, unclosed string with zero byte
    push_text("Or(1.2.3\"a");
    qbuf.push_back(8'h00);
    push_text("b");
    send_query(1'b0);
    // skipped bytes, lone equals, all math ops, lone bang, dangling dot
    qbuf.push_back(8'h00);
    qbuf.push_back(8'hFF);
    push_text("=>+-*/%!.");
    send_query(1'b0);
    push_text("<=>=!=<");
    send_query(1'b0);
    send_query(1'b0);

    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    while (random_items < 900) begin
      src_gaps    = !(round >= 30 && round < 60);
      sink_stalls = src_gaps;
      gen_query(noise);
      if (!noise) random_items += qbuf.size() + 1;
      send_query(round == 3 || $urandom_range(0, 9) == 0);
      round++;
    end

    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    // text lengths past the saturation point
    push_word(135);
    qbuf.push_back(CH_SPACE);
    push_digits(131);
    qbuf.push_back(CH_SPACE);
    push_string(130, 1'b1);
    send_query(1'b0);
    // exactly fills the token slots, then overruns them with RPAREN tokens and an identifier
    repeat (TOKEN_CAP - 1) qbuf.push_back(CH_LPAR);
    send_query(1'b0);
    repeat (TOKEN_CAP + 8) qbuf.push_back(CH_RPAR);
    push_text("ab");
    send_query(1'b0);
    // position saturates before the string opens
    repeat (POS_CAP + 4) qbuf.push_back(CH_SPACE);
    push_text("\"ab");
    send_query(1'b0);

    s_axis_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
